// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stream merger.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the asynchronous active-low reset.
`define SPSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spsm assertion failed");

// Next-cycle implication under the asynchronous active-low reset.
`define SPSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spsm assertion failed");

`endif

// ===== rtl/core/spsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream merger package
// Field widths, operation codes, payload types and cell control type.
// ----------------------------------------------------------------------------
package spsm_pkg;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned RATE_W    = 20;
	localparam int unsigned FRAMES_W  = 13;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned TIME_W    = 33;
	localparam int unsigned IV_W      = 20;
	localparam int unsigned FIDX_W    = 12;
	localparam int unsigned OSLOT_W   = 4;

	localparam int unsigned ONE_SECOND_US    = 1000000;
	localparam int unsigned DEFAULT_INTERVAL = 250;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic                ready_req;
		logic [RATE_W-1:0]   packets_per_sec;
		logic [FRAMES_W-1:0] frame_count;
		logic [ID_W-1:0]     publisher_id;
	} in_t;

	typedef struct packed {
		logic                entry_valid;
		logic [TIME_W-1:0]   entry_time_us;
		logic [ID_W-1:0]     owner_id;
		logic [OSLOT_W-1:0]  owner_slot;
		logic [FIDX_W-1:0]   frame_index;
		logic [TIME_W-1:0]   cycle_duration_us;
		logic                last_entry;
	} out_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic clear;
		logic load;
		logic rewind;
		logic set_iv;
		logic set_off;
		logic advance;
	} cell_ctl_t;

endpackage

// ===== rtl/core/spsm_if.sv =====
// ----------------------------------------------------------------------------
// Stream merger channels
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface spsm_in_if;
	logic         valid;
	logic         ready;
	spsm_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spsm_out_if;
	logic          valid;
	logic          ready;
	spsm_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/staggered_periodic_stream_merger.sv =====
// One transaction is in flight at a time; clear and load complete in the idle state.
// A next request on a finalized schedule waits in the pick state while the earliest-entry
// search ripples down the row, then steps through advance and last when it found an entry.
// The first next request after a clear or load also finalizes: an interval divide per ready
// publisher with a nonzero rate, a stagger divide, then offset and end per ready publisher.
// Reset clears all slots, the schedule and the output valid flag at once.
// ----------------------------------------------------------------------------
// Staggered periodic stream merger
// Loads publisher records into a row of cells, finalizes a staggered schedule
// and returns the earliest pending entry on each next request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module staggered_periodic_stream_merger #(
	parameter int MAX_PUBLISHERS = 16,
	parameter int MAX_FRAMES     = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	spsm_in_if.sink    in_ch,
	spsm_out_if.source out_ch
);
	localparam int SW = (MAX_PUBLISHERS > 1) ? $clog2(MAX_PUBLISHERS) : 1;
	localparam int CW = $clog2(MAX_PUBLISHERS + 1);
	localparam int IV_W = spsm_pkg::IV_W;
	localparam int TIME_W = spsm_pkg::TIME_W;
	localparam int FR_W = spsm_pkg::FRAMES_W;
	localparam int ID_W = spsm_pkg::ID_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_DIVW  = 4'd2;
	localparam logic [3:0] ST_STAG  = 4'd3;
	localparam logic [3:0] ST_STAGW = 4'd4;
	localparam logic [3:0] ST_OFF   = 4'd5;
	localparam logic [3:0] ST_END   = 4'd6;
	localparam logic [3:0] ST_PICK  = 4'd7;
	localparam logic [3:0] ST_ADV   = 4'd8;
	localparam logic [3:0] ST_LAST  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]          st_q;
	logic [CW-1:0]       cnt_q;
	logic                fin_q;
	logic [CW-1:0]       scan_q;
	logic [CW-1:0]       wait_q;
	logic [CW-1:0]       rdy_cnt_q;
	logic                min_none_q;
	logic [IV_W-1:0]     min_q;
	logic [IV_W-1:0]     stag_q;
	logic [IV_W-1:0]     off_acc_q;
	logic [TIME_W-1:0]   cyc_q;
	logic [TIME_W-1:0]   prod_s1;
	logic [IV_W-1:0]     off_s1;
	logic                nz_s1;
	logic                res_vld_q;
	logic [TIME_W-1:0]   res_time_q;
	logic [ID_W-1:0]     res_id_q;
	logic [SW-1:0]       adv_slot_q;
	logic [FR_W-1:0]     res_frame_q;
	logic                res_last_q;
	logic                out_vld_q;
	spsm_pkg::out_t      out_q;

	logic                in_acc;
	logic                scan_end;
	logic [SW-1:0]       sel_idx;
	spsm_pkg::cell_ctl_t ctl;
	logic [IV_W-1:0]     wr_val;
	logic [FR_W-1:0]     sat_frames;
	logic [IV_W-1:0]     min_eff;
	logic                div_start;
	logic [IV_W-1:0]     div_a;
	logic [IV_W-1:0]     div_b;
	logic                div_busy;
	logic                div_done;
	logic [IV_W-1:0]     div_q;
	logic [TIME_W-1:0]   end_time;

	logic [MAX_PUBLISHERS-1:0] cell_sel;
	logic [MAX_PUBLISHERS-1:0] act_rdy;
	logic [MAX_PUBLISHERS-1:0] pend;
	logic [spsm_pkg::RATE_W-1:0] rate_a [MAX_PUBLISHERS];
	logic [FR_W-1:0]     frames_a [MAX_PUBLISHERS];
	logic [IV_W-1:0]     iv_a [MAX_PUBLISHERS];
	logic [FR_W-1:0]     next_a [MAX_PUBLISHERS];
	logic                bv_a [MAX_PUBLISHERS];
	logic [TIME_W-1:0]   bt_a [MAX_PUBLISHERS];
	logic [ID_W-1:0]     bi_a [MAX_PUBLISHERS];
	logic [SW-1:0]       bs_a [MAX_PUBLISHERS];

	logic                          sel_rdy;
	logic [spsm_pkg::RATE_W-1:0]   sel_rate;
	logic [FR_W-1:0]               sel_frames;
	logic [IV_W-1:0]               sel_iv;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign scan_end = (scan_q == cnt_q);
	assign min_eff  = min_none_q ? IV_W'(spsm_pkg::DEFAULT_INTERVAL) : min_q;

	// Frame counts above the limit saturate.
	always_comb begin
		if (32'(in_ch.data.frame_count) > 32'(MAX_FRAMES)) begin
			sat_frames = FR_W'(MAX_FRAMES);
		end else begin
			sat_frames = in_ch.data.frame_count;
		end
	end

	// Slot addressed by the sequencer.
	always_comb begin
		priority if (st_q == ST_IDLE) begin
			sel_idx = cnt_q[SW-1:0];
		end else if (st_q == ST_ADV) begin
			sel_idx = adv_slot_q;
		end else begin
			sel_idx = scan_q[SW-1:0];
		end
	end

	assign sel_rdy    = act_rdy[sel_idx];
	assign sel_rate   = rate_a[sel_idx];
	assign sel_frames = frames_a[sel_idx];
	assign sel_iv     = iv_a[sel_idx];

	// Commands to the cells.
	always_comb begin
		ctl.clear   = in_acc && (in_ch.data.opcode == spsm_pkg::OP_CLEAR);
		ctl.load    = in_acc && (in_ch.data.opcode == spsm_pkg::OP_LOAD) &&
			(cnt_q < CW'(MAX_PUBLISHERS));
		ctl.rewind  = in_acc && (in_ch.data.opcode == spsm_pkg::OP_NEXT) && !fin_q;
		ctl.set_iv  = ((st_q == ST_SCAN) && !scan_end && sel_rdy && (sel_rate == '0)) ||
			((st_q == ST_DIVW) && div_done);
		ctl.set_off = (st_q == ST_OFF) && !scan_end && sel_rdy;
		ctl.advance = (st_q == ST_ADV);
	end

	always_comb begin
		unique case (st_q)
			ST_SCAN: wr_val = IV_W'(spsm_pkg::DEFAULT_INTERVAL);
			ST_DIVW: wr_val = div_q;
			default: wr_val = off_acc_q;
		endcase
	end

	// Shared divider: rate intervals, then the stagger.
	always_comb begin
		div_start = ((st_q == ST_SCAN) && !scan_end && sel_rdy && (sel_rate != '0)) ||
			((st_q == ST_STAG) && (rdy_cnt_q != '0));
		div_a = (st_q == ST_SCAN) ? IV_W'(spsm_pkg::ONE_SECOND_US) : min_eff;
		div_b = (st_q == ST_SCAN) ? IV_W'(sel_rate) : IV_W'(rdy_cnt_q);
	end

	spsm_div #(.W(IV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// Row of cells; the earliest-entry search ripples from slot 0 upward.
	for (genvar i = 0; i < MAX_PUBLISHERS; i++) begin : g_cell
		logic              pv;
		logic [TIME_W-1:0] pt;
		logic [ID_W-1:0]   pi;
		logic [SW-1:0]     ps;
		if (i == 0) begin : g_head
			assign pv = 1'b0;
			assign pt = '0;
			assign pi = '0;
			assign ps = '0;
		end else begin : g_link
			assign pv = bv_a[i-1];
			assign pt = bt_a[i-1];
			assign pi = bi_a[i-1];
			assign ps = bs_a[i-1];
		end
		assign cell_sel[i] = (sel_idx == SW'(i));
		spsm_cell #(.SW(SW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (cell_sel[i]),
			.my_slot    (SW'(i)),
			.rec_ready  (in_ch.data.ready_req),
			.rec_rate   (in_ch.data.packets_per_sec),
			.rec_frames (sat_frames),
			.rec_id     (in_ch.data.publisher_id),
			.wr_val     (wr_val),
			.prev_vld   (pv),
			.prev_time  (pt),
			.prev_id    (pi),
			.prev_slot  (ps),
			.act_ready  (act_rdy[i]),
			.rate       (rate_a[i]),
			.frames     (frames_a[i]),
			.iv         (iv_a[i]),
			.next_frame (next_a[i]),
			.pending    (pend[i]),
			.best_vld   (bv_a[i]),
			.best_time  (bt_a[i]),
			.best_id    (bi_a[i]),
			.best_slot  (bs_a[i])
		);
	end

	assign end_time = prod_s1 + TIME_W'(off_s1);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			cnt_q      <= '0;
			fin_q      <= 1'b0;
			scan_q     <= '0;
			wait_q     <= '0;
			rdy_cnt_q  <= '0;
			min_none_q <= 1'b1;
			min_q      <= '0;
			stag_q     <= '0;
			off_acc_q  <= '0;
			cyc_q      <= '0;
			res_vld_q  <= 1'b0;
			res_last_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if ((st_q == ST_OUT) && (!out_vld_q || out_ch.ready)) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (ctl.clear) begin
						cnt_q <= '0;
						fin_q <= 1'b0;
						cyc_q <= '0;
					end else if (in_acc && (in_ch.data.opcode == spsm_pkg::OP_LOAD)) begin
						fin_q <= 1'b0;
						if (ctl.load) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (in_acc && (in_ch.data.opcode == spsm_pkg::OP_NEXT)) begin
						wait_q <= '0;
						if (fin_q) begin
							st_q <= ST_PICK;
						end else begin
							scan_q     <= '0;
							rdy_cnt_q  <= '0;
							min_none_q <= 1'b1;
							st_q       <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						st_q <= ST_STAG;
					end else if (div_start) begin
						st_q <= ST_DIVW;
					end else begin
						if (sel_rdy) begin
							rdy_cnt_q <= rdy_cnt_q + 1'b1;
						end
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						if (min_none_q || (div_q < min_q)) begin
							min_q <= div_q;
						end
						min_none_q <= 1'b0;
						rdy_cnt_q  <= rdy_cnt_q + 1'b1;
						scan_q     <= scan_q + 1'b1;
						st_q       <= ST_SCAN;
					end
				end
				ST_STAG: begin
					scan_q    <= '0;
					off_acc_q <= '0;
					cyc_q     <= '0;
					if (div_start) begin
						st_q <= ST_STAGW;
					end else begin
						stag_q <= '0;
						st_q   <= ST_OFF;
					end
				end
				ST_STAGW: begin
					if (div_done) begin
						stag_q <= div_q;
						st_q   <= ST_OFF;
					end
				end
				ST_OFF: begin
					if (scan_end) begin
						fin_q  <= 1'b1;
						wait_q <= '0;
						st_q   <= ST_PICK;
					end else if (sel_rdy) begin
						off_acc_q <= off_acc_q + stag_q;
						st_q      <= ST_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_END: begin
					if (nz_s1 && (end_time > cyc_q)) begin
						cyc_q <= end_time;
					end
					scan_q <= scan_q + 1'b1;
					st_q   <= ST_OFF;
				end
				ST_PICK: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == CW'(MAX_PUBLISHERS)) begin
						res_vld_q <= bv_a[MAX_PUBLISHERS-1];
						if (bv_a[MAX_PUBLISHERS-1]) begin
							st_q <= ST_ADV;
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_ADV: begin
					st_q <= ST_LAST;
				end
				ST_LAST: begin
					res_last_q <= ~|pend;
					st_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_vld_q || out_ch.ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Finalize datapath: end time of each ready slot, one multiply per slot.
	always_ff @(posedge clk) begin
		if (ctl.set_off) begin
			prod_s1 <= TIME_W'({{IV_W{1'b0}}, sel_frames} * {{FR_W{1'b0}}, sel_iv});
			off_s1  <= off_acc_q;
			nz_s1   <= (sel_frames != '0);
		end
	end

	// Winner capture and result register.
	always_ff @(posedge clk) begin
		if ((st_q == ST_PICK) && (wait_q == CW'(MAX_PUBLISHERS))) begin
			res_time_q  <= bt_a[MAX_PUBLISHERS-1];
			res_id_q    <= bi_a[MAX_PUBLISHERS-1];
			adv_slot_q  <= bs_a[MAX_PUBLISHERS-1];
		end
		if (ctl.advance) begin
			res_frame_q <= next_a[adv_slot_q];
		end
		if ((st_q == ST_OUT) && (!out_vld_q || out_ch.ready)) begin
			out_q.entry_valid       <= res_vld_q;
			out_q.entry_time_us     <= res_vld_q ? res_time_q : '0;
			out_q.owner_id          <= res_vld_q ? res_id_q : '0;
			out_q.owner_slot        <= res_vld_q ? spsm_pkg::OSLOT_W'(adv_slot_q) : '0;
			out_q.frame_index       <= res_vld_q ? res_frame_q[spsm_pkg::FIDX_W-1:0] : '0;
			out_q.cycle_duration_us <= cyc_q;
			out_q.last_entry        <= res_vld_q ? res_last_q : 1'b0;
		end
	end

	assign in_ch.ready  = (st_q == ST_IDLE);
	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_q;

	`SPSM_ASSERT_NOW(a_out_after_fin, clk, arst_n, st_q == ST_OUT, fin_q)
	`SPSM_ASSERT_NOW(a_div_not_busy, clk, arst_n, div_start, !div_busy)
	`SPSM_ASSERT_NEXT(a_clear_empties, clk, arst_n, ctl.clear, (cnt_q == '0) && !fin_q)
endmodule

// ===== rtl/core/spsm_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spsm_div #(
	parameter int W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic             take;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
		take  = ~trial[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift together.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/spsm_cell.sv =====
// ----------------------------------------------------------------------------
// Publisher cell
// Holds one publisher slot and passes the running earliest entry onward.
// ----------------------------------------------------------------------------
module spsm_cell #(
	parameter int SW = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spsm_pkg::cell_ctl_t             ctl,
	input  logic                            sel,
	input  logic [SW-1:0]                   my_slot,
	input  logic                            rec_ready,
	input  logic [spsm_pkg::RATE_W-1:0]     rec_rate,
	input  logic [spsm_pkg::FRAMES_W-1:0]   rec_frames,
	input  logic [spsm_pkg::ID_W-1:0]       rec_id,
	input  logic [spsm_pkg::IV_W-1:0]       wr_val,
	input  logic                            prev_vld,
	input  logic [spsm_pkg::TIME_W-1:0]     prev_time,
	input  logic [spsm_pkg::ID_W-1:0]       prev_id,
	input  logic [SW-1:0]                   prev_slot,
	output logic                            act_ready,
	output logic [spsm_pkg::RATE_W-1:0]     rate,
	output logic [spsm_pkg::FRAMES_W-1:0]   frames,
	output logic [spsm_pkg::IV_W-1:0]       iv,
	output logic [spsm_pkg::FRAMES_W-1:0]   next_frame,
	output logic                            pending,
	output logic                            best_vld,
	output logic [spsm_pkg::TIME_W-1:0]     best_time,
	output logic [spsm_pkg::ID_W-1:0]       best_id,
	output logic [SW-1:0]                   best_slot
);
	logic                            used_q;
	logic                            ready_q;
	logic [spsm_pkg::FRAMES_W-1:0]   next_q;
	logic [spsm_pkg::RATE_W-1:0]     rate_q;
	logic [spsm_pkg::FRAMES_W-1:0]   frames_q;
	logic [spsm_pkg::ID_W-1:0]       id_q;
	logic [spsm_pkg::IV_W-1:0]       iv_q;
	logic [spsm_pkg::TIME_W-1:0]     time_q;
	logic                            best_vld_q;
	logic [spsm_pkg::TIME_W-1:0]     best_time_q;
	logic [spsm_pkg::ID_W-1:0]       best_id_q;
	logic [SW-1:0]                   best_slot_q;
	logic                            own_wins;

	// Control state of the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			ready_q <= 1'b0;
			next_q  <= '0;
		end else if (ctl.clear) begin
			used_q  <= 1'b0;
			ready_q <= 1'b0;
			next_q  <= '0;
		end else if (ctl.load && sel) begin
			used_q  <= 1'b1;
			ready_q <= rec_ready;
			next_q  <= '0;
		end else if (ctl.rewind) begin
			next_q <= '0;
		end else if (ctl.advance && sel) begin
			next_q <= next_q + 1'b1;
		end
	end

	// Payload of the slot and its running timestamp.
	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			rate_q   <= rec_rate;
			frames_q <= rec_frames;
			id_q     <= rec_id;
		end
		if (ctl.set_iv && sel) begin
			iv_q <= wr_val;
		end
		if (ctl.set_off && sel) begin
			time_q <= spsm_pkg::TIME_W'(wr_val);
		end else if (ctl.advance && sel) begin
			time_q <= time_q + spsm_pkg::TIME_W'(iv_q);
		end
	end

	assign pending = used_q && ready_q && (next_q < frames_q);

	// The earlier entry wins; on equal time the lower id, then the lower slot.
	always_comb begin
		own_wins = pending && (!prev_vld || (time_q < prev_time) ||
			((time_q == prev_time) && (id_q < prev_id)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else begin
			best_vld_q <= own_wins || prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		best_time_q <= own_wins ? time_q : prev_time;
		best_id_q   <= own_wins ? id_q : prev_id;
		best_slot_q <= own_wins ? my_slot : prev_slot;
	end

	assign act_ready  = used_q && ready_q;
	assign rate       = rate_q;
	assign frames     = frames_q;
	assign iv         = iv_q;
	assign next_frame = next_q;
	assign best_vld   = best_vld_q;
	assign best_time  = best_time_q;
	assign best_id    = best_id_q;
	assign best_slot  = best_slot_q;
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Stream merger testbench
// Drives a directed table and then random publisher sequences into the merger.
// A local schedule model predicts each result not typed in the table, and the checker
// compares each result field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	typedef spsm_pkg::in_t  in_t;
	typedef spsm_pkg::out_t out_t;

	localparam int OP_W    = spsm_pkg::OP_W;
	localparam int TIME_W  = spsm_pkg::TIME_W;
	localparam int OSLOT_W = spsm_pkg::OSLOT_W;
	localparam int FIDX_W  = spsm_pkg::FIDX_W;

	localparam int NUM_SLOTS   = 16;
	localparam int FRAME_LIMIT = 4096;
	localparam int NUM_ITEMS   = 1500;
	localparam int DRAIN_WAIT  = 400;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		in_t  req;
		bit   typed;
		out_t answer;
	} row_t;

	logic clk;
	logic arst_n;
	spsm_in_if  in_ch ();
	spsm_out_if out_ch ();

	staggered_periodic_stream_merger u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Schedule model state.
	bit          sch_ready [NUM_SLOTS];
	bit [19:0]   sch_rate [NUM_SLOTS];
	bit [63:0]   sch_iv [NUM_SLOTS];
	bit [63:0]   sch_off [NUM_SLOTS];
	bit [12:0]   sch_frames [NUM_SLOTS];
	bit [15:0]   sch_ident [NUM_SLOTS];
	bit [12:0]   sch_next [NUM_SLOTS];
	int          sch_loaded;
	bit          sch_final;
	bit [63:0]   sch_cycle;

	out_t        pending_entries [$];
	int          errors;
	longint      cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_requests;
	int          hold_seen;
	int          hold_left;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic bit [63:0] interval_for(bit [19:0] rate);
		return (rate == 0) ? 64'(spsm_pkg::DEFAULT_INTERVAL) :
			64'(spsm_pkg::ONE_SECOND_US) / rate;
	endfunction

	function automatic void build_schedule();
		int nready;
		int idx;
		bit [63:0] min_iv;
		bit [63:0] stagger;
		bit [63:0] stop;
		bit have_min;
		nready = 0;
		idx = 0;
		have_min = 0;
		min_iv = 0;
		stagger = 0;
		for (int s = 0; s < sch_loaded; s++) begin
			if (sch_ready[s]) begin
				nready++;
				if (sch_rate[s] != 0 && (!have_min || interval_for(sch_rate[s]) < min_iv)) begin
					min_iv = interval_for(sch_rate[s]);
					have_min = 1;
				end
			end
		end
		if (!have_min)
			min_iv = spsm_pkg::DEFAULT_INTERVAL;
		if (nready != 0)
			stagger = min_iv / nready;
		sch_cycle = 0;
		for (int s = 0; s < sch_loaded; s++) begin
			sch_next[s] = 0;
			if (sch_ready[s]) begin
				sch_iv[s] = interval_for(sch_rate[s]);
				sch_off[s] = idx * stagger;
				if (sch_frames[s] > 0) begin
					stop = sch_off[s] + sch_frames[s] * sch_iv[s];
					if (stop > sch_cycle)
						sch_cycle = stop;
				end
				idx++;
			end
		end
		sch_final = 1;
	endfunction

	function automatic int earliest_slot();
		int best;
		bit [63:0] best_t;
		bit [63:0] t;
		best = -1;
		best_t = 0;
		for (int s = 0; s < sch_loaded; s++) begin
			if (sch_ready[s] && sch_next[s] < sch_frames[s]) begin
				t = sch_off[s] + sch_next[s] * sch_iv[s];
				if (best < 0 || t < best_t || (t == best_t && sch_ident[s] < sch_ident[best])) begin
					best = s;
					best_t = t;
				end
			end
		end
		return best;
	endfunction

	// Updates the model with one transaction; returns 1 when it yields a result.
	function automatic bit merge_step(in_t req, output out_t res);
		int s;
		res = '0;
		unique case (req.opcode)
			spsm_pkg::OP_CLEAR: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					sch_ready[i] = 0;
					sch_next[i] = 0;
				end
				sch_loaded = 0;
				sch_final = 0;
				sch_cycle = 0;
				return 0;
			end
			spsm_pkg::OP_LOAD: begin
				if (sch_loaded < NUM_SLOTS) begin
					sch_ready[sch_loaded] = req.ready_req;
					sch_rate[sch_loaded] = req.packets_per_sec;
					sch_frames[sch_loaded] = (req.frame_count > FRAME_LIMIT) ?
						13'(FRAME_LIMIT) : req.frame_count;
					sch_ident[sch_loaded] = req.publisher_id;
					sch_next[sch_loaded] = 0;
					sch_loaded++;
				end
				sch_final = 0;
				return 0;
			end
			spsm_pkg::OP_NEXT: begin
				if (!sch_final)
					build_schedule();
				res.cycle_duration_us = sch_cycle[TIME_W-1:0];
				s = earliest_slot();
				if (s >= 0) begin
					res.entry_valid = 1;
					res.entry_time_us = TIME_W'(sch_off[s] + sch_next[s] * sch_iv[s]);
					res.owner_id = sch_ident[s];
					res.owner_slot = OSLOT_W'(s);
					res.frame_index = sch_next[s][FIDX_W-1:0];
					sch_next[s]++;
					res.last_entry = (earliest_slot() < 0);
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// Offers one transaction and records its prediction once it is accepted.
	task automatic offer(in_t req, bit typed = 0, out_t answer = '0);
		out_t res;
		in_ch.valid = 1'b1;
		in_ch.data = req;
		do @(posedge clk); while (!in_ch.ready);
		if (merge_step(req, res))
			pending_entries = {pending_entries, (typed ? answer : res)};
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			in_ch.data = in_t'({$urandom, $urandom});
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	function automatic in_t make_req(logic [OP_W-1:0] op, bit rdy, bit [19:0] rate,
			bit [12:0] fc, bit [15:0] id);
		in_t r;
		r.opcode = op;
		r.ready_req = rdy;
		r.packets_per_sec = rate;
		r.frame_count = fc;
		r.publisher_id = id;
		return r;
	endfunction

	function automatic out_t make_out(bit v, bit [32:0] ts, bit [15:0] id, bit [3:0] slot,
			bit [11:0] fi, bit [32:0] dur, bit last);
		out_t o;
		o.entry_valid = v;
		o.entry_time_us = ts;
		o.owner_id = id;
		o.owner_slot = slot;
		o.frame_index = fi;
		o.cycle_duration_us = dur;
		o.last_entry = last;
		return o;
	endfunction

	function automatic bit [19:0] pick_rate();
		int k;
		k = $urandom_range(0, 99);
		if (k < 10) return 0;
		if (k < 15) return 20'(spsm_pkg::ONE_SECOND_US);
		if (k < 25) return 20'($urandom);
		return 20'($urandom_range(1, 8000));
	endfunction

	function automatic bit [12:0] pick_frames();
		int k;
		k = $urandom_range(0, 99);
		if (k < 3) return 13'($urandom);
		if (k < 6) return 13'($urandom_range(4090, 4100));
		return 13'($urandom_range(0, 5));
	endfunction

	// One publisher set: mostly a clear, then a run of loads, then a run of next requests.
	task automatic publisher_sequence(ref int count);
		int nload;
		int nnext;
		int total;
		bit [12:0] fc;
		if ($urandom_range(0, 9) != 0) begin
			offer(make_req(spsm_pkg::OP_CLEAR, 1'($urandom), 20'($urandom), 13'($urandom),
				16'($urandom)));
			count++;
		end
		nload = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
		total = 0;
		for (int i = 0; i < nload; i++) begin
			fc = pick_frames();
			total += (fc > FRAME_LIMIT) ? FRAME_LIMIT : fc;
			offer(make_req(spsm_pkg::OP_LOAD, $urandom_range(0, 5) != 0, pick_rate(), fc,
				16'($urandom)));
			count++;
		end
		nnext = (total > 30) ? $urandom_range(5, 30) : total + $urandom_range(0, 2);
		for (int i = 0; i < nnext; i++) begin
			// Now and then a load lands in the middle of the schedule.
			if ($urandom_range(0, 19) == 0)
				offer(make_req(spsm_pkg::OP_LOAD, 1'b1, pick_rate(), pick_frames(),
					16'($urandom)));
			else
				offer(make_req(spsm_pkg::OP_NEXT, 1'($urandom), 20'($urandom), 13'($urandom),
					16'($urandom)));
			count++;
		end
	endtask

	// Result checker.
	always @(posedge clk) begin
		out_t got;
		out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_entries.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				want = pending_entries.pop_front();
				if (got.entry_valid !== want.entry_valid) begin
					$error("entry_valid: expected %0d, got %0d", want.entry_valid, got.entry_valid);
					errors++;
				end
				if (got.entry_time_us !== want.entry_time_us) begin
					$error("entry_time_us: expected %0d, got %0d",
						want.entry_time_us, got.entry_time_us);
					errors++;
				end
				if (got.owner_id !== want.owner_id) begin
					$error("owner_id: expected %0d, got %0d", want.owner_id, got.owner_id);
					errors++;
				end
				if (got.owner_slot !== want.owner_slot) begin
					$error("owner_slot: expected %0d, got %0d", want.owner_slot, got.owner_slot);
					errors++;
				end
				if (got.frame_index !== want.frame_index) begin
					$error("frame_index: expected %0d, got %0d", want.frame_index, got.frame_index);
					errors++;
				end
				if (got.cycle_duration_us !== want.cycle_duration_us) begin
					$error("cycle_duration_us: expected %0d, got %0d",
						want.cycle_duration_us, got.cycle_duration_us);
					errors++;
				end
				if (got.last_entry !== want.last_entry) begin
					$error("last_entry: expected %0d, got %0d", want.last_entry, got.last_entry);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls plus a single long hold-off.
	initial begin
		out_ch.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Stimulus.
	initial begin
		row_t table_rows [$];
		int count;
		errors = 0;
		cycles = 0;
		hold_requests = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; rows with a typed answer use it instead of the model.
		table_rows = '{
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 1, make_out(0, 0, 0, 0, 0, 0, 0)},
			'{make_req(OP_UNUSED, 1, 20'hFFFFF, 13'h1FFF, 16'hFFFF), 0, '0},
			'{make_req(spsm_pkg::OP_LOAD, 1, 20'(spsm_pkg::ONE_SECOND_US), 1, 16'hFFFF), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 1, make_out(1, 0, 16'hFFFF, 0, 0, 1, 1)},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 1, make_out(0, 0, 0, 0, 0, 1, 0)},
			'{make_req(spsm_pkg::OP_CLEAR, 1, 20'hFFFFF, 13'h1FFF, 16'hFFFF), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 1, 0, 0, 0), 1, make_out(0, 0, 0, 0, 0, 0, 0)},
			'{make_req(spsm_pkg::OP_LOAD, 1, 0, 13'h1FFF, 7), 0, '0},
			'{make_req(spsm_pkg::OP_LOAD, 0, 20'hFFFFF, 3, 0), 0, '0},
			'{make_req(spsm_pkg::OP_LOAD, 1, 20'hFFFFF, 2, 3), 0, '0},
			'{make_req(spsm_pkg::OP_LOAD, 1, 1, 1, 3), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_LOAD, 1, 4000, 3, 0), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 0), 0, '0},
			'{make_req(spsm_pkg::OP_CLEAR, 0, 0, 0, 0), 0, '0}
		};
		foreach (table_rows[i])
			offer(table_rows[i].req, table_rows[i].typed, table_rows[i].answer);

		// Random part in four idling phases.
		count = 0;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 68 : (phase == 3) ? 22 : 0;
			recv_stall_pct = (phase == 2) ? 68 : (phase == 3) ? 22 : 0;
			while (count < (phase + 1) * NUM_ITEMS / 4) begin
				if ($urandom_range(0, 19) == 0) begin
					offer(in_t'({$urandom, $urandom}));
					count++;
				end else begin
					publisher_sequence(count);
				end
			end
			// Long receiver hold-off while next requests keep coming.
			if (phase == 0) begin
				hold_requests++;
				for (int i = 0; i < 12; i++) begin
					offer(make_req(spsm_pkg::OP_NEXT, 0, 0, 0, 16'($urandom)));
					count++;
				end
			end
			// Sender pause until every result is in.
			in_ch.valid = 1'b0;
			while (pending_entries.size() != 0) @(negedge clk);
		end

		in_ch.valid = 1'b0;
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
